[rtl/mm_pkg.sv]
// ============================================================================
// Matrix multiply package
// Item types, function and register codes, and the sequencer program ROM.
// ============================================================================
`default_nettype none

package mm_pkg;

    // Field widths fixed by the item format
    localparam int VAL_W     = 32;  // Q16.16 element
    localparam int FRAC_W    = 16;
    localparam int IDX_W     = 2;   // row / column fields
    localparam int FUNC_W    = 2;
    localparam int DIM_REG_W = 3;   // dimension registers
    localparam int CFG_IDX_W = 2;

    localparam logic [DIM_REG_W-1:0] DIM_RESET = 3'd4;

    // Input function codes
    localparam logic [FUNC_W-1:0] FN_LOAD_LEFT  = 2'd0;
    localparam logic [FUNC_W-1:0] FN_LOAD_RIGHT = 2'd1;
    localparam logic [FUNC_W-1:0] FN_START      = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ROWS_LEFT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INNER_SIZE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COLS_RIGHT = 2'd2;

    typedef struct packed {
        logic [FUNC_W-1:0]       func;
        logic [IDX_W-1:0]        row_index;
        logic [IDX_W-1:0]        col_index;
        logic signed [VAL_W-1:0] element_value;
    } t_in_item;

    typedef struct packed {
        logic [IDX_W-1:0]        out_row;
        logic [IDX_W-1:0]        out_col;
        logic signed [VAL_W-1:0] out_value;
        logic                    last;
    } t_out_item;

    // MAC unit control
    typedef struct packed {
        logic clear;    // load accumulator with the rounding bias
        logic vld;      // operands on the RAM outputs are valid
    } t_mac_ctl;

    // Sequencer steps
    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] S_IDLE   = 4'd0;
    localparam logic [STEP_W-1:0] S_START  = 4'd1;
    localparam logic [STEP_W-1:0] S_CHECK  = 4'd2;
    localparam logic [STEP_W-1:0] S_ISSUE  = 4'd3;
    localparam logic [STEP_W-1:0] S_DRAIN1 = 4'd4;
    localparam logic [STEP_W-1:0] S_DRAIN2 = 4'd5;
    localparam logic [STEP_W-1:0] S_EMIT   = 4'd6;
    localparam logic [STEP_W-1:0] S_NEXT   = 4'd7;
    localparam logic [STEP_W-1:0] S_DONE   = 4'd8;

    // Jump conditions: jump to target when true, else fall through
    localparam int COND_W = 3;
    localparam logic [COND_W-1:0] C_NEVER    = 3'd0;
    localparam logic [COND_W-1:0] C_ALWAYS   = 3'd1;
    localparam logic [COND_W-1:0] C_NO_START = 3'd2;
    localparam logic [COND_W-1:0] C_EMPTY    = 3'd3;
    localparam logic [COND_W-1:0] C_N_ZERO   = 3'd4;
    localparam logic [COND_W-1:0] C_MORE_K   = 3'd5;
    localparam logic [COND_W-1:0] C_OUT_BUSY = 3'd6;
    localparam logic [COND_W-1:0] C_NOT_LAST = 3'd7;

    typedef struct packed {
        logic              issue;    // read both stores, step k
        logic              emit;     // load output register (when free)
        logic              clr_acc;
        logic              clr_idx;  // i = j = k = 0
        logic              adv_idx;  // next result element, k = 0
        logic [COND_W-1:0] cond;
        logic [STEP_W-1:0] target;
    } t_ucode;

    function automatic t_ucode ucode_rom(input logic [STEP_W-1:0] step);
        t_ucode w;
        w = '0;
        case (step)
            S_IDLE: begin
                w.cond   = C_NO_START;
                w.target = S_IDLE;
            end
            S_START: begin
                w.clr_acc = 1'b1;
                w.clr_idx = 1'b1;
                w.cond    = C_EMPTY;
                w.target  = S_IDLE;
            end
            S_CHECK: begin
                w.cond   = C_N_ZERO;
                w.target = S_DRAIN1;
            end
            S_ISSUE: begin
                w.issue  = 1'b1;
                w.cond   = C_MORE_K;
                w.target = S_ISSUE;
            end
            S_DRAIN1: begin
                w.cond = C_NEVER;
            end
            S_DRAIN2: begin
                w.cond = C_NEVER;
            end
            S_EMIT: begin
                w.emit   = 1'b1;
                w.cond   = C_OUT_BUSY;
                w.target = S_EMIT;
            end
            S_NEXT: begin
                w.clr_acc = 1'b1;
                w.adv_idx = 1'b1;
                w.cond    = C_NOT_LAST;
                w.target  = S_CHECK;
            end
            S_DONE: begin
                w.cond   = C_ALWAYS;
                w.target = S_IDLE;
            end
            default: begin
                w.cond   = C_ALWAYS;
                w.target = S_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

[rtl/mm_ram.sv]
// ============================================================================
// Generic RAM
// One write port, one read port, registered read data.
// ============================================================================
`default_nettype none

module mm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[rtl/mm_mac.sv]
// ============================================================================
// Multiply-accumulate unit
// Registered 32x32 signed product, wide exact accumulator, rounding to
// Q16.16 and saturation to 32 bits.
// ============================================================================
`default_nettype none

module mm_mac #(
    parameter int MAX_DIM = 4
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire mm_pkg::t_mac_ctl               i_ctl,
    input  wire logic signed [mm_pkg::VAL_W-1:0] i_left,
    input  wire logic signed [mm_pkg::VAL_W-1:0] i_right,
    output logic signed      [mm_pkg::VAL_W-1:0] o_value,
    output logic                                o_busy
);

    localparam int PROD_W = 2 * mm_pkg::VAL_W;
    // Room for MAX_DIM full-scale products plus the rounding bias
    localparam int ACC_W  = PROD_W + $clog2(MAX_DIM) + 1;
    localparam int TOP_LO = mm_pkg::VAL_W + mm_pkg::FRAC_W - 1;

    localparam logic signed [ACC_W-1:0] ACC_BIAS =
        ACC_W'(1) << (mm_pkg::FRAC_W - 1);
    localparam logic signed [mm_pkg::VAL_W-1:0] VAL_MAX =
        {1'b0, {(mm_pkg::VAL_W-1){1'b1}}};
    localparam logic signed [mm_pkg::VAL_W-1:0] VAL_MIN =
        {1'b1, {(mm_pkg::VAL_W-1){1'b0}}};

    logic signed [PROD_W-1:0] r_prod;
    logic                     r_prod_vld;
    logic signed [ACC_W-1:0]  r_acc;
    logic [ACC_W-1-TOP_LO:0]  acc_top;
    logic                     ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_vld <= 1'b0;
        end else begin
            r_prod_vld <= i_ctl.vld;
        end
    end

    // Product register, then accumulate
    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(i_left) * PROD_W'(i_right);
        if (i_ctl.clear) begin
            r_acc <= ACC_BIAS;
        end else if (r_prod_vld) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
    end

    // acc holds sum + 1/2 lsb; floor by dropping fraction, then saturate
    assign acc_top = r_acc[ACC_W-1:TOP_LO];
    assign ovf     = (|acc_top) && !(&acc_top);
    assign o_value = ovf ? (r_acc[ACC_W-1] ? VAL_MIN : VAL_MAX)
                         : r_acc[TOP_LO:mm_pkg::FRAC_W];
    assign o_busy  = r_prod_vld;

endmodule

`default_nettype wire

[rtl/matrix_multiply_top.sv]
// Results: after a start transaction each result element is computed in turn
// by the one shared multiply-accumulate unit and its 2-stage read/multiply
// pipe, then loaded into the output register; the sequencer waits while the
// output register is still held by a stall. Input is stalled for the whole
// multiply. Reset clears control and sets all three dimension registers to 4;
// the matrix stores are not cleared.
// ============================================================================
// Matrix multiply top level
// Microcoded sequencer over two element RAMs and one MAC unit. Loads write
// the left or right store; start walks every result element in row-major
// order and sends it out through a registered output stage.
// ============================================================================
`default_nettype none

module matrix_multiply_top #(
    parameter int MAX_DIM = 4
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // item input
    input  wire logic                             i_in_valid,
    output logic                                  o_in_stall,
    input  wire mm_pkg::t_in_item                 i_in_data,
    // result output
    output logic                                  o_out_valid,
    input  wire logic                             i_out_stall,
    output mm_pkg::t_out_item                     o_out_data,
    // configuration writes
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [mm_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [mm_pkg::DIM_REG_W-1:0]     i_cfg_data
);

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int DIM_W  = $clog2(MAX_DIM + 1);   // holds 0..MAX_DIM
    localparam logic [ADDR_W-1:0] ROW_STRIDE = ADDR_W'(MAX_DIM);

    // ------------------------------------------------------------------
    // Configuration registers. Always ready; writes take effect at once, unchecked:
    // the user must change dimensions only while no multiply is running.
    // ------------------------------------------------------------------
    logic [mm_pkg::DIM_REG_W-1:0] r_rows;
    logic [mm_pkg::DIM_REG_W-1:0] r_inner;
    logic [mm_pkg::DIM_REG_W-1:0] r_cols;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows  <= mm_pkg::DIM_RESET;
            r_inner <= mm_pkg::DIM_RESET;
            r_cols  <= mm_pkg::DIM_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                mm_pkg::REG_ROWS_LEFT:  r_rows  <= i_cfg_data;
                mm_pkg::REG_INNER_SIZE: r_inner <= i_cfg_data;
                mm_pkg::REG_COLS_RIGHT: r_cols  <= i_cfg_data;
                default: ;  // writes past the register list are dropped
            endcase
        end
    end

    // Dimensions above MAX_DIM act as MAX_DIM
    logic [DIM_W-1:0] dim_m;
    logic [DIM_W-1:0] dim_n;
    logic [DIM_W-1:0] dim_p;

    assign dim_m = (int'(r_rows)  > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(r_rows);
    assign dim_n = (int'(r_inner) > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(r_inner);
    assign dim_p = (int'(r_cols)  > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(r_cols);

    // ------------------------------------------------------------------
    // Sequencer: step counter addressing the program ROM
    // ------------------------------------------------------------------
    logic [mm_pkg::STEP_W-1:0] r_step;
    logic [mm_pkg::STEP_W-1:0] n_step;
    mm_pkg::t_ucode            uc;

    logic [DIM_W-1:0] r_i;      // result row
    logic [DIM_W-1:0] r_j;      // result column
    logic [DIM_W-1:0] r_k;      // inner index
    logic [DIM_W-1:0] n_i;
    logic [DIM_W-1:0] n_j;
    logic [DIM_W-1:0] n_k;

    logic r_rd_vld;             // RAM read data valid this cycle
    logic mac_busy;

    logic in_acc;
    logic start_acc;
    logic load_ok;
    logic more_k;
    logic last_elem;
    logic out_busy;
    logic do_emit;
    logic jump;

    assign uc = mm_pkg::ucode_rom(r_step);

    // Items are taken only while the program sits in its idle step
    assign o_in_stall = (r_step != mm_pkg::S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign start_acc  = in_acc && (i_in_data.func == mm_pkg::FN_START);

    assign more_k    = ((DIM_W+1)'(r_k) + (DIM_W+1)'(1)) < (DIM_W+1)'(dim_n);
    assign last_elem = (((DIM_W+1)'(r_i) + (DIM_W+1)'(1)) == (DIM_W+1)'(dim_m))
                    && (((DIM_W+1)'(r_j) + (DIM_W+1)'(1)) == (DIM_W+1)'(dim_p));
    assign out_busy  = o_out_valid && i_out_stall;
    assign do_emit   = uc.emit && !out_busy;

    always_comb begin
        case (uc.cond)
            mm_pkg::C_NEVER:    jump = 1'b0;
            mm_pkg::C_ALWAYS:   jump = 1'b1;
            mm_pkg::C_NO_START: jump = !start_acc;
            mm_pkg::C_EMPTY:    jump = (dim_m == '0) || (dim_p == '0);
            mm_pkg::C_N_ZERO:   jump = (dim_n == '0);
            mm_pkg::C_MORE_K:   jump = more_k;
            mm_pkg::C_OUT_BUSY: jump = out_busy;
            mm_pkg::C_NOT_LAST: jump = !last_elem;
            default:            jump = 1'b0;
        endcase
        n_step = jump ? uc.target : r_step + mm_pkg::STEP_W'(1);
    end

    // Index counters: k steps during reads, (i, j) walk row-major
    always_comb begin
        n_i = r_i;
        n_j = r_j;
        n_k = r_k;
        if (uc.clr_idx) begin
            n_i = '0;
            n_j = '0;
            n_k = '0;
        end else if (uc.adv_idx) begin
            n_k = '0;
            if (((DIM_W+1)'(r_j) + (DIM_W+1)'(1)) == (DIM_W+1)'(dim_p)) begin
                n_j = '0;
                n_i = r_i + DIM_W'(1);
            end else begin
                n_j = r_j + DIM_W'(1);
            end
        end else if (uc.issue) begin
            n_k = r_k + DIM_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step   <= mm_pkg::S_IDLE;
            r_rd_vld <= 1'b0;
            r_i      <= '0;
            r_j      <= '0;
            r_k      <= '0;
        end else begin
            r_step   <= n_step;
            r_rd_vld <= uc.issue;
            r_i      <= n_i;
            r_j      <= n_j;
            r_k      <= n_k;
        end
    end

    // ------------------------------------------------------------------
    // Element stores, addressed row * MAX_DIM + col
    // ------------------------------------------------------------------
    logic                     we_left;
    logic                     we_right;
    logic [ADDR_W-1:0]        waddr;
    logic [ADDR_W-1:0]        raddr_left;
    logic [ADDR_W-1:0]        raddr_right;
    logic [mm_pkg::VAL_W-1:0] rdata_left;
    logic [mm_pkg::VAL_W-1:0] rdata_right;

    // Loads outside the store are dropped
    assign load_ok  = (int'(i_in_data.row_index) < MAX_DIM)
                   && (int'(i_in_data.col_index) < MAX_DIM);
    assign we_left  = in_acc && load_ok && (i_in_data.func == mm_pkg::FN_LOAD_LEFT);
    assign we_right = in_acc && load_ok && (i_in_data.func == mm_pkg::FN_LOAD_RIGHT);
    assign waddr    = ADDR_W'(i_in_data.row_index) * ROW_STRIDE
                    + ADDR_W'(i_in_data.col_index);

    // Left reads row i, right reads column j, both at inner index k
    assign raddr_left  = ADDR_W'(r_i) * ROW_STRIDE + ADDR_W'(r_k);
    assign raddr_right = ADDR_W'(r_k) * ROW_STRIDE + ADDR_W'(r_j);

    mm_ram #(
        .WIDTH (mm_pkg::VAL_W),
        .DEPTH (DEPTH),
        .ADDR_W(ADDR_W)
    ) u_left_store (
        .i_clk  (i_clk),
        .i_we   (we_left),
        .i_waddr(waddr),
        .i_wdata(i_in_data.element_value),
        .i_raddr(raddr_left),
        .o_rdata(rdata_left)
    );

    mm_ram #(
        .WIDTH (mm_pkg::VAL_W),
        .DEPTH (DEPTH),
        .ADDR_W(ADDR_W)
    ) u_right_store (
        .i_clk  (i_clk),
        .i_we   (we_right),
        .i_waddr(waddr),
        .i_wdata(i_in_data.element_value),
        .i_raddr(raddr_right),
        .o_rdata(rdata_right)
    );

    // ------------------------------------------------------------------
    // Shared MAC
    // ------------------------------------------------------------------
    mm_pkg::t_mac_ctl                   mac_ctl;
    logic signed [mm_pkg::VAL_W-1:0]    mac_value;

    assign mac_ctl.clear = uc.clr_acc;
    assign mac_ctl.vld   = r_rd_vld;

    mm_mac #(
        .MAX_DIM(MAX_DIM)
    ) u_mac (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (mac_ctl),
        .i_left (rdata_left),
        .i_right(rdata_right),
        .o_value(mac_value),
        .o_busy (mac_busy)
    );

    // ------------------------------------------------------------------
    // Output register: holds a finished result until its transaction
    // ------------------------------------------------------------------
    logic              r_out_valid;
    mm_pkg::t_out_item r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (do_emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_emit) begin
            r_out.out_row   <= mm_pkg::IDX_W'(r_i);
            r_out.out_col   <= mm_pkg::IDX_W'(r_j);
            r_out.out_value <= mac_value;
            r_out.last      <= last_elem;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef ASSERT_OFF
    // The accumulator must be complete when a result is taken from it
    a_emit_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step == mm_pkg::S_EMIT) |-> (!r_rd_vld && !mac_busy))
        else $error("result emitted with MAC pipeline still busy");

    // Reads stay inside the configured inner dimension
    a_issue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step == mm_pkg::S_ISSUE) |-> (r_k < dim_n))
        else $error("store read beyond inner size");

    // Every emitted element lies inside the result matrix
    a_emit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_emit |-> ((r_i < dim_m) && (r_j < dim_p)))
        else $error("result element outside the result matrix");

    // The product pipeline only fills from an issued read
    a_mac_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mac_busy |-> $past(r_rd_vld))
        else $error("MAC product without a store read");
`endif

endmodule

`default_nettype wire
